FILE: rtl/cpot_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Collider pair overlap test: shared package
// Widths, shape pair codes, pipeline stage map and the words passed between
// the pipeline modules.
// ----------------------------------------------------------------------------
package cpot_pkg;

  localparam int COORD_BITS = 24;
  localparam int SIZE_BITS  = 23;
  localparam int CMD_BITS   = 2;

  // box corners hold a position plus a size
  localparam int BOX_BITS   = COORD_BITS + 1;
  // clamped point minus centre
  localparam int DIFF_BITS  = BOX_BITS + 1;
  // radius or sum of two radii
  localparam int REACH_BITS = SIZE_BITS + 1;
  localparam int SQ_BITS    = 2 * REACH_BITS;
  localparam int SUM_BITS   = SQ_BITS + 1;

  localparam int NSTG      = 6;
  localparam int STG_SETUP = 0;
  localparam int STG_CLAMP = 1;
  localparam int STG_DIFF  = 2;
  localparam int STG_ABS   = 3;
  localparam int STG_SQ    = 4;
  localparam int STG_CMP   = 5;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_RECT_RECT = 2'd0,
    CMD_CIRC_CIRC = 2'd1,
    CMD_CIRC_RECT = 2'd2,
    CMD_RECT_CIRC = 2'd3
  } cmd_e;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [SIZE_BITS-1:0]  size_t;
  typedef logic signed [BOX_BITS-1:0]   box_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic        [DIFF_BITS-1:0]  mag_t;
  typedef logic        [REACH_BITS-1:0] reach_t;
  typedef logic        [SQ_BITS-1:0]    sq_t;
  typedef logic        [SUM_BITS-1:0]   sum_t;

  typedef struct packed {
    logic [NSTG-1:0] en;
    logic [NSTG-1:0] vld;
  } cpot_ctl_t;

  typedef struct packed {
    logic [CMD_BITS-1:0] cmd;
    coord_t              a_x;
    coord_t              a_y;
    size_t               a_w;
    size_t               a_h;
    coord_t              b_x;
    coord_t              b_y;
    size_t               b_w;
    size_t               b_h;
    logic                both_active;
  } cpot_req_t;

  // p is the box, q the other box or the point to clamp
  typedef struct packed {
    logic   active;
    logic   is_rr;
    box_t   p_lo_x;
    box_t   p_hi_x;
    box_t   p_lo_y;
    box_t   p_hi_y;
    box_t   q_lo_x;
    box_t   q_hi_x;
    box_t   q_lo_y;
    box_t   q_hi_y;
    reach_t reach;
  } cpot_s1_t;

  typedef struct packed {
    logic   active;
    logic   is_rr;
    logic   rr_hit;
    logic   far;
    reach_t mx;
    reach_t my;
    reach_t reach;
  } cpot_s4_t;

endpackage

FILE: rtl/cpot_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Collider pair overlap test: channel interfaces
// Valid/ready channels for the collider pair word and the result word.
// ----------------------------------------------------------------------------
interface cpot_in_if import cpot_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_BITS-1:0] cmd;
  coord_t              a_x;
  coord_t              a_y;
  size_t               a_w;
  size_t               a_h;
  coord_t              b_x;
  coord_t              b_y;
  size_t               b_w;
  size_t               b_h;
  logic                both_active;

  modport source (
    output valid, cmd, a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h, both_active,
    input  ready
  );
  modport sink (
    input  valid, cmd, a_x, a_y, a_w, a_h, b_x, b_y, b_w, b_h, both_active,
    output ready
  );
endinterface

interface cpot_out_if ();
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

FILE: rtl/cpot_flow.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Collider pair overlap test: pipeline flow control
// Per-stage valid bits and load enables; a stage loads when it is empty or
// the stage after it moves.
// ----------------------------------------------------------------------------
module cpot_flow import cpot_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  output cpot_ctl_t ctl_o
);

  logic [NSTG-1:0] vld_q, vld_d;
  logic [NSTG-1:0] load;
  logic [NSTG-1:0] prev;

  always_comb begin
    load[NSTG-1] = !vld_q[NSTG-1] || out_ready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      load[k] = !vld_q[k] || load[k+1];
    end
    prev = {vld_q[NSTG-2:0], in_valid_i};
    for (int k = 0; k < NSTG; k++) begin
      vld_d[k] = load[k] ? prev[k] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = load[0];
  assign out_valid_o = vld_q[NSTG-1];
  assign ctl_o.en    = load & prev;
  assign ctl_o.vld   = vld_q;

  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&vld_q))
    else $error("input blocked while a stage is empty");

  a_drain_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !vld_q[NSTG-2]) |=> !out_valid_o)
    else $error("delivered word repeated");

endmodule

FILE: rtl/cpot_setup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Collider pair overlap test: setup stage
// Map the shape pair onto one box and one query box or point, form the box
// far edges and the reach.
// ----------------------------------------------------------------------------
module cpot_setup import cpot_pkg::*; (
  input  logic      clk_i,
  input  logic      en_i,
  input  cpot_req_t req_i,
  output cpot_s1_t  s1_o
);

  cpot_s1_t s1_d, s1_q;
  box_t     ax, ay, bx, by;
  box_t     ax_hi, ay_hi, bx_hi, by_hi;

  always_comb begin
    ax    = box_t'(req_i.a_x);
    ay    = box_t'(req_i.a_y);
    bx    = box_t'(req_i.b_x);
    by    = box_t'(req_i.b_y);
    ax_hi = ax + box_t'(req_i.a_w);
    ay_hi = ay + box_t'(req_i.a_h);
    bx_hi = bx + box_t'(req_i.b_w);
    by_hi = by + box_t'(req_i.b_h);

    s1_d        = '0;
    s1_d.active = req_i.both_active;
    unique case (cmd_e'(req_i.cmd))
      CMD_RECT_RECT: begin
        s1_d.is_rr  = 1'b1;
        s1_d.p_lo_x = ax;
        s1_d.p_hi_x = ax_hi;
        s1_d.p_lo_y = ay;
        s1_d.p_hi_y = ay_hi;
        s1_d.q_lo_x = bx;
        s1_d.q_hi_x = bx_hi;
        s1_d.q_lo_y = by;
        s1_d.q_hi_y = by_hi;
        s1_d.reach  = '0;
      end
      CMD_CIRC_CIRC: begin
        s1_d.p_lo_x = bx;
        s1_d.p_hi_x = bx;
        s1_d.p_lo_y = by;
        s1_d.p_hi_y = by;
        s1_d.q_lo_x = ax;
        s1_d.q_hi_x = ax;
        s1_d.q_lo_y = ay;
        s1_d.q_hi_y = ay;
        s1_d.reach  = reach_t'(req_i.a_w) + reach_t'(req_i.b_w);
      end
      CMD_CIRC_RECT: begin
        s1_d.p_lo_x = bx;
        s1_d.p_hi_x = bx_hi;
        s1_d.p_lo_y = by;
        s1_d.p_hi_y = by_hi;
        s1_d.q_lo_x = ax;
        s1_d.q_hi_x = ax;
        s1_d.q_lo_y = ay;
        s1_d.q_hi_y = ay;
        s1_d.reach  = reach_t'(req_i.a_w);
      end
      CMD_RECT_CIRC: begin
        s1_d.p_lo_x = ax;
        s1_d.p_hi_x = ax_hi;
        s1_d.p_lo_y = ay;
        s1_d.p_hi_y = ay_hi;
        s1_d.q_lo_x = bx;
        s1_d.q_hi_x = bx;
        s1_d.q_lo_y = by;
        s1_d.q_hi_y = by;
        s1_d.reach  = reach_t'(req_i.b_w);
      end
      default: s1_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
    end
  end

  assign s1_o = s1_q;

endmodule

FILE: rtl/cpot_clamp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Collider pair overlap test: clamp stages
// Box overlap compare and clamp of the point into the box, then the offset
// to the clamped point, then its magnitude and the far-apart check.
// ----------------------------------------------------------------------------
module cpot_clamp import cpot_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cpot_ctl_t ctl_i,
  input  cpot_s1_t  s1_i,
  output cpot_s4_t  s4_o
);

  // clamp stage
  logic   s2_active_q, s2_is_rr_q, s2_rr_hit_q;
  box_t   s2_px_q, s2_py_q, s2_cx_q, s2_cy_q;
  reach_t s2_reach_q;
  logic   rr_hit_d;
  box_t   px_d, py_d;

  // offset stage
  logic   s3_active_q, s3_is_rr_q, s3_rr_hit_q;
  diff_t  s3_dx_q, s3_dy_q;
  reach_t s3_reach_q;

  // magnitude stage
  cpot_s4_t s4_d, s4_q;
  mag_t     mag_x, mag_y;

  always_comb begin
    rr_hit_d = ($signed(s1_i.q_lo_x) <= $signed(s1_i.p_hi_x)) &&
               ($signed(s1_i.p_lo_x) <= $signed(s1_i.q_hi_x)) &&
               ($signed(s1_i.q_lo_y) <= $signed(s1_i.p_hi_y)) &&
               ($signed(s1_i.p_lo_y) <= $signed(s1_i.q_hi_y));
    if ($signed(s1_i.q_lo_x) < $signed(s1_i.p_lo_x)) begin
      px_d = s1_i.p_lo_x;
    end else if ($signed(s1_i.q_lo_x) > $signed(s1_i.p_hi_x)) begin
      px_d = s1_i.p_hi_x;
    end else begin
      px_d = s1_i.q_lo_x;
    end
    if ($signed(s1_i.q_lo_y) < $signed(s1_i.p_lo_y)) begin
      py_d = s1_i.p_lo_y;
    end else if ($signed(s1_i.q_lo_y) > $signed(s1_i.p_hi_y)) begin
      py_d = s1_i.p_hi_y;
    end else begin
      py_d = s1_i.q_lo_y;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[STG_CLAMP]) begin
      s2_active_q <= s1_i.active;
      s2_is_rr_q  <= s1_i.is_rr;
      s2_rr_hit_q <= rr_hit_d;
      s2_px_q     <= px_d;
      s2_py_q     <= py_d;
      s2_cx_q     <= s1_i.q_lo_x;
      s2_cy_q     <= s1_i.q_lo_y;
      s2_reach_q  <= s1_i.reach;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[STG_DIFF]) begin
      s3_active_q <= s2_active_q;
      s3_is_rr_q  <= s2_is_rr_q;
      s3_rr_hit_q <= s2_rr_hit_q;
      s3_dx_q     <= diff_t'(s2_px_q) - diff_t'(s2_cx_q);
      s3_dy_q     <= diff_t'(s2_py_q) - diff_t'(s2_cy_q);
      s3_reach_q  <= s2_reach_q;
    end
  end

  always_comb begin
    mag_x       = s3_dx_q[DIFF_BITS-1] ? mag_t'(-s3_dx_q) : mag_t'(s3_dx_q);
    mag_y       = s3_dy_q[DIFF_BITS-1] ? mag_t'(-s3_dy_q) : mag_t'(s3_dy_q);
    s4_d.active = s3_active_q;
    s4_d.is_rr  = s3_is_rr_q;
    s4_d.rr_hit = s3_rr_hit_q;
    s4_d.far    = (mag_x > mag_t'(s3_reach_q)) || (mag_y > mag_t'(s3_reach_q));
    s4_d.mx     = reach_t'(mag_x);
    s4_d.my     = reach_t'(mag_y);
    s4_d.reach  = s3_reach_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[STG_ABS]) begin
      s4_q <= s4_d;
    end
  end

  assign s4_o = s4_q;

  a_near_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.en[STG_ABS] && !s4_d.far) |->
      (mag_x <= mag_t'(s3_reach_q) && mag_y <= mag_t'(s3_reach_q)))
    else $error("offset magnitude truncated while within reach");

endmodule

FILE: rtl/cpot_dist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Collider pair overlap test: distance stages
// Square both offsets and the reach, then compare the distance with the
// reach and pick the box or circle answer.
// ----------------------------------------------------------------------------
module cpot_dist import cpot_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cpot_ctl_t ctl_i,
  input  cpot_s4_t  s4_i,
  output logic      hit_o
);

  logic s5_active_q, s5_is_rr_q, s5_rr_hit_q, s5_far_q;
  sq_t  s5_sqx_q, s5_sqy_q, s5_r2_q;
  sum_t dist2;
  logic hit_d, hit_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[STG_SQ]) begin
      s5_active_q <= s4_i.active;
      s5_is_rr_q  <= s4_i.is_rr;
      s5_rr_hit_q <= s4_i.rr_hit;
      s5_far_q    <= s4_i.far;
      s5_sqx_q    <= sq_t'(s4_i.mx) * sq_t'(s4_i.mx);
      s5_sqy_q    <= sq_t'(s4_i.my) * sq_t'(s4_i.my);
      s5_r2_q     <= sq_t'(s4_i.reach) * sq_t'(s4_i.reach);
    end
  end

  always_comb begin
    dist2 = sum_t'(s5_sqx_q) + sum_t'(s5_sqy_q);
    if (!s5_active_q) begin
      hit_d = 1'b0;
    end else if (s5_is_rr_q) begin
      hit_d = s5_rr_hit_q;
    end else begin
      hit_d = !s5_far_q && (dist2 <= sum_t'(s5_r2_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[STG_CMP]) begin
      hit_q <= hit_d;
    end
  end

  assign hit_o = hit_q;

  a_inactive_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.en[STG_CMP] && !s5_active_q) |=> !hit_o)
    else $error("hit reported for an inactive pair");

endmodule

FILE: rtl/collider_pair_overlap_test_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Collider pair overlap test: top level
// Throughput: one pair per cycle while the output is ready; six register stages
// (setup, clamp, offset, magnitude, square, compare) each hold one word and
// move when the next frees.
// Reset: asynchronous, active low; clears the stage valid bits only.
// ----------------------------------------------------------------------------
module collider_pair_overlap_test_top import cpot_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  cpot_in_if.sink         in_i,
  cpot_out_if.source      out_o
);

  cpot_ctl_t ctl;
  cpot_req_t req;
  cpot_s1_t  s1;
  cpot_s4_t  s4;
  logic      in_ready;
  logic      out_valid;
  logic      hit;

  assign req.cmd         = in_i.cmd;
  assign req.a_x         = in_i.a_x;
  assign req.a_y         = in_i.a_y;
  assign req.a_w         = in_i.a_w;
  assign req.a_h         = in_i.a_h;
  assign req.b_x         = in_i.b_x;
  assign req.b_y         = in_i.b_y;
  assign req.b_w         = in_i.b_w;
  assign req.b_h         = in_i.b_h;
  assign req.both_active = in_i.both_active;

  cpot_flow u_flow (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .ctl_o       (ctl)
  );

  cpot_setup u_setup (
    .clk_i (clk_i),
    .en_i  (ctl.en[STG_SETUP]),
    .req_i (req),
    .s1_o  (s1)
  );

  cpot_clamp u_clamp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .s1_i   (s1),
    .s4_o   (s4)
  );

  cpot_dist u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .s4_i   (s4),
    .hit_o  (hit)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.hit   = hit;

endmodule

FILE: tb/collider_pair_overlap_test_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Collider pair overlap test: testbench
// Sends collider pair words through the valid/ready input channel and checks
// every hit word against an in-order list of predicted answers. A directed
// set of edge, zero-size, extreme and inactive pairs comes first. Random
// pairs follow, mostly near each other so that hits and misses both occur.
// They run under four idle/stall mixes, with one long output hold-off and a
// drain between phases.
// ----------------------------------------------------------------------------

class hit_tracker;
  bit expected_hits[$];
  int errors;
  int touched;
  int missed;

  static function longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  static function longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  static function bit in_reach(longint dx, longint dy, longint reach);
    longint ax;
    longint ay;
    ax = mag(dx);
    ay = mag(dy);
    if (ax > reach || ay > reach) return 1'b0;
    return (ax * ax + ay * ay) <= reach * reach;
  endfunction

  static function bit rect_circle(longint rx, longint ry, longint rw, longint rh,
                                  longint cx, longint cy, longint cr);
    longint px;
    longint py;
    px = clamp(cx, rx, rx + rw);
    py = clamp(cy, ry, ry + rh);
    return in_reach(px - cx, py - cy, cr);
  endfunction

  static function bit pair_touches(cpot_pkg::cpot_req_t r);
    longint ax, ay, aw, ah, bx, by, bw, bh;
    ax = r.a_x;
    ay = r.a_y;
    aw = r.a_w;
    ah = r.a_h;
    bx = r.b_x;
    by = r.b_y;
    bw = r.b_w;
    bh = r.b_h;
    if (!r.both_active) return 1'b0;
    case (cpot_pkg::cmd_e'(r.cmd))
      cpot_pkg::CMD_RECT_RECT:
        return !(ax > bx + bw || ax + aw < bx || ay > by + bh || ay + ah < by);
      cpot_pkg::CMD_CIRC_CIRC: return in_reach(ax - bx, ay - by, aw + bw);
      cpot_pkg::CMD_CIRC_RECT: return rect_circle(bx, by, bw, bh, ax, ay, aw);
      default:                 return rect_circle(ax, ay, aw, ah, bx, by, bw);
    endcase
  endfunction

  function void note_pair(cpot_pkg::cpot_req_t r);
    expected_hits.push_back(pair_touches(r));
  endfunction

  function void check_hit(logic hit);
    bit want;
    if (expected_hits.size() == 0) begin
      $error("hit word with no pair outstanding: actual %0b", hit);
      errors++;
      return;
    end
    want = expected_hits.pop_front();
    if (hit !== want) begin
      $error("hit mismatch: expected %0b, actual %0b", want, hit);
      errors++;
    end
    if (want) touched++;
    else missed++;
  endfunction

  function int pending();
    return expected_hits.size();
  endfunction
endclass

module collider_pair_overlap_test_top_tb;
  import cpot_pkg::*;

  localparam int HOLD_CYCLES = 200;
  localparam int RAND_PAIRS  = 1130;
  localparam int NPHASE      = 4;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic      src_valid = 1'b0;
  cpot_req_t src_word = '0;
  logic      sink_ready = 1'b0;

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int holds_asked = 0;
  int holds_served;
  int hold_left;
  int pairs_sent = 0;

  hit_tracker book = new();

  cpot_in_if  in_if ();
  cpot_out_if out_if ();

  assign in_if.valid       = src_valid;
  assign in_if.cmd         = src_word.cmd;
  assign in_if.a_x         = src_word.a_x;
  assign in_if.a_y         = src_word.a_y;
  assign in_if.a_w         = src_word.a_w;
  assign in_if.a_h         = src_word.a_h;
  assign in_if.b_x         = src_word.b_x;
  assign in_if.b_y         = src_word.b_y;
  assign in_if.b_w         = src_word.b_w;
  assign in_if.b_h         = src_word.b_h;
  assign in_if.both_active = src_word.both_active;
  assign out_if.ready      = sink_ready;

  collider_pair_overlap_test_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  // hold off the output for a long stretch on request, else stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sink_ready   <= 1'b0;
      hold_left    <= 0;
      holds_served <= 0;
    end else if (holds_served != holds_asked) begin
      sink_ready   <= 1'b0;
      hold_left    <= HOLD_CYCLES - 1;
      holds_served <= holds_asked;
    end else if (hold_left != 0) begin
      sink_ready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else begin
      sink_ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) book.check_hit(out_if.hit);
  end

  task automatic send_pair(cpot_req_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      src_valid <= 1'b0;
      @(posedge clk_i);
    end
    src_valid <= 1'b1;
    src_word  <= r;
    do @(posedge clk_i); while (!in_if.ready);
    book.note_pair(r);
    pairs_sent++;
  endtask

  task automatic drain();
    src_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
  endtask

  function automatic cpot_req_t mk(cmd_e c, int ax, int ay, int aw, int ah,
                                   int bx, int by, int bw, int bh, bit act);
    cpot_req_t r;
    r.cmd         = c;
    r.a_x         = coord_t'(ax);
    r.a_y         = coord_t'(ay);
    r.a_w         = size_t'(aw);
    r.a_h         = size_t'(ah);
    r.b_x         = coord_t'(bx);
    r.b_y         = coord_t'(by);
    r.b_w         = size_t'(bw);
    r.b_h         = size_t'(bh);
    r.both_active = act;
    return r;
  endfunction

  function automatic cpot_req_t random_pair();
    cpot_req_t   r;
    int unsigned span;
    longint      ox;
    longint      oy;
    r.cmd         = CMD_BITS'($urandom_range(3));
    r.both_active = ($urandom_range(15) != 0);
    r.a_x         = coord_t'($urandom);
    r.a_y         = coord_t'($urandom);
    if ($urandom_range(3) == 0) begin
      r.a_w = size_t'($urandom);
      r.a_h = size_t'($urandom);
      r.b_x = coord_t'($urandom);
      r.b_y = coord_t'($urandom);
      r.b_w = size_t'($urandom);
      r.b_h = size_t'($urandom);
    end else begin
      // keep B near A so that the pair sits close to the touching boundary
      span  = 1 << $urandom_range(22);
      r.a_w = size_t'($urandom_range(span));
      r.a_h = size_t'($urandom_range(span));
      r.b_w = size_t'($urandom_range(span));
      r.b_h = size_t'($urandom_range(span));
      ox    = longint'($urandom_range(4 * span)) - 2 * longint'(span);
      oy    = longint'($urandom_range(4 * span)) - 2 * longint'(span);
      r.b_x = coord_t'(longint'(r.a_x) + ox);
      r.b_y = coord_t'(longint'(r.a_y) + oy);
    end
    return r;
  endfunction

  initial begin
    cpot_req_t edge_pairs[$];
    int        idle_mix[NPHASE];
    int        stall_mix[NPHASE];

    idle_mix  = '{0, 86, 0, 38};
    stall_mix = '{0, 0, 86, 38};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    edge_pairs.push_back(mk(CMD_RECT_RECT, 0, 0, 256, 256, 256, 0, 256, 256, 1'b1));
    edge_pairs.push_back(mk(CMD_RECT_RECT, 0, 0, 256, 256, 257, 0, 256, 256, 1'b1));
    edge_pairs.push_back(mk(CMD_RECT_RECT, 100, 100, 0, 0, 100, 50, 0, 50, 1'b1));
    edge_pairs.push_back(mk(CMD_RECT_RECT, -8388608, -8388608, 8388607, 8388607,
                            8388607, 8388607, 8388607, 8388607, 1'b1));
    edge_pairs.push_back(mk(CMD_RECT_RECT, -8388608, -8388608, 0, 0,
                            -8388608, -8388608, 0, 0, 1'b1));
    edge_pairs.push_back(mk(CMD_CIRC_CIRC, 0, 0, 640, 0, 768, 1024, 640, 0, 1'b1));
    edge_pairs.push_back(mk(CMD_CIRC_CIRC, 0, 0, 640, 0, 768, 1024, 639, 0, 1'b1));
    edge_pairs.push_back(mk(CMD_CIRC_CIRC, -8388608, -8388608, 8388607, 8388607,
                            8388607, 8388607, 8388607, 8388607, 1'b1));
    edge_pairs.push_back(mk(CMD_CIRC_CIRC, -8388608, 8388607, 8388607, 0,
                            8388607, -8388608, 8388607, 0, 1'b1));
    edge_pairs.push_back(mk(CMD_CIRC_CIRC, 5, -5, 0, 0, 5, -5, 0, 0, 1'b1));
    edge_pairs.push_back(mk(CMD_CIRC_RECT, -100, 50, 100, 0, 0, 0, 200, 200, 1'b1));
    edge_pairs.push_back(mk(CMD_CIRC_RECT, -100, 50, 99, 0, 0, 0, 200, 200, 1'b1));
    edge_pairs.push_back(mk(CMD_CIRC_RECT, 50, 50, 0, 0, 0, 0, 200, 200, 1'b1));
    edge_pairs.push_back(mk(CMD_RECT_CIRC, 0, 0, 300, 400, 1068, 1424, 1280, 0, 1'b1));
    edge_pairs.push_back(mk(CMD_RECT_CIRC, 0, 0, 300, 400, 1068, 1424, 1279, 0, 1'b1));
    edge_pairs.push_back(mk(CMD_RECT_CIRC, -8388608, -8388608, 8388607, 8388607,
                            8388607, 8388607, 8388607, 8388607, 1'b1));
    edge_pairs.push_back(mk(CMD_RECT_CIRC, 8388607, 8388607, 0, 0,
                            -8388608, -8388608, 0, 0, 1'b1));
    edge_pairs.push_back(mk(CMD_RECT_RECT, 0, 0, 256, 256, 0, 0, 256, 256, 1'b0));
    edge_pairs.push_back(mk(CMD_CIRC_CIRC, 0, 0, 256, 0, 0, 0, 256, 0, 1'b0));
    edge_pairs.push_back(mk(CMD_CIRC_RECT, 10, 10, 256, 0, 0, 0, 256, 256, 1'b0));
    edge_pairs.push_back(mk(CMD_RECT_CIRC, 0, 0, 256, 256, 10, 10, 256, 0, 1'b0));

    foreach (edge_pairs[i]) send_pair(edge_pairs[i]);
    drain();

    for (int p = 0; p < NPHASE; p++) begin
      src_idle_pct  = idle_mix[p];
      snk_stall_pct = stall_mix[p];
      // long output hold-off while pairs keep coming, to fill the pipeline
      if (p == 0) holds_asked <= holds_asked + 1;
      for (int i = 0; i < RAND_PAIRS / NPHASE; i++) send_pair(random_pair());
      drain();
    end

    repeat (20) @(posedge clk_i);
    $display("Checked %0d collider pairs over all four shape pairs and four throttle mixes.",
             pairs_sent);
    $display("Results: %0d touching, %0d apart, %0d left unanswered.",
             book.touched, book.missed, book.pending());
    if (book.errors == 0 && book.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d pairs outstanding", book.pending());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
